/* sv/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, bus codes and address helpers of the character LCD terminal.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned MaxBusItems = 3;

  // Bus command and character codes.
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_LINE2     = 8'hC0;
  localparam logic [7:0] CHR_NUL       = 8'h00;
  localparam logic [7:0] CHR_BS        = 8'h08;
  localparam logic [7:0] CHR_ESC       = 8'h1B;
  localparam logic [7:0] CHR_SPACE     = 8'h20;
  localparam logic [7:0] ESC_OFFSET    = 8'h20;
  localparam logic [7:0] ESC_ROW_ONE   = 8'h21;

  // DDRAM addresses and line geometry.
  localparam logic [6:0] ADDR_HOME      = 7'h00;
  localparam logic [6:0] ADDR_LINE2     = 7'h40;
  localparam logic [6:0] ADDR_LINE1_END = 7'h27;
  localparam logic [6:0] ADDR_LINE2_END = 7'h67;
  localparam logic [6:0] LINE_LENGTH    = 7'd40;
  localparam logic [5:0] LAST_COL_RESET = 6'd19;

  typedef enum logic [3:0] {
    ESC_IDLE = 4'b0001,
    ESC_EQ   = 4'b0010,
    ESC_ROW  = 4'b0100,
    ESC_COL  = 4'b1000
  } esc_phase_e;

  typedef struct packed {
    logic [6:0] cursor;
    esc_phase_e phase;
    logic       row_one;
  } term_state_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } bus_item_t;

  typedef struct packed {
    logic [1:0]                  count;
    bus_item_t [MaxBusItems-1:0] items;
  } step_out_t;

  // Address counter step after a data write.
  function automatic logic [6:0] adv_addr(input logic [6:0] a);
    logic [6:0] r;
    if (a == ADDR_LINE1_END) begin
      r = ADDR_LINE2;
    end else if (a == ADDR_LINE2_END) begin
      r = ADDR_HOME;
    end else begin
      r = a + 7'd1;
    end
    return r;
  endfunction

  // Set-position command one place back; stays at home and clamps to the last column on line 1.
  function automatic logic [7:0] bs_cmd(input logic [6:0] a, input logic [5:0] last_col);
    logic [6:0] d;
    logic [6:0] target;
    d = a - 7'd1;
    if (a == ADDR_HOME) begin
      target = ADDR_HOME;
    end else if (d >= ADDR_LINE2) begin
      target = d;
    end else if (d > {1'b0, last_col}) begin
      target = {1'b0, last_col};
    end else begin
      target = d;
    end
    return {1'b1, target};
  endfunction

endpackage

/* sv/char_lcd_text_terminal.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_terminal
// Turns a stream of text bytes into data and command bytes for a two-line
// character LCD, tracking the display address internally.
// ----------------------------------------------------------------------------
// Each text item is registered, decoded combinationally and its bus items (none
// to three) are loaded into a three-entry output buffer that sends one item
// per cycle while the receiver is ready. The first bus item leaves the buffer
// after the input register and then the buffer have taken the text item. The
// next text item is decoded as the last bus item of the previous one leaves,
// so input is taken while the buffer still drains: plain text gives one bus
// item, a line wrap two and a backspace three. tlast marks the last bus item
// of each text item; tuser is high for a character write and low for a command.
module char_lcd_text_terminal (
  input  logic       clk_i,
  input  logic       rst_ni,
  // APB register port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  // Text input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  // LCD bus output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] lcd_byte
  output logic       m_axis_tuser,   // [0] is_data
  output logic       m_axis_tlast
);
  import clt_pkg::*;

  localparam logic REG_LAST_COLUMN = 1'b0;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [5:0]  last_col_q;
  term_state_t state_q;
  term_state_t state_d;
  step_out_t   step_res;
  logic [1:0]  cnt_q;
  bus_item_t [MaxBusItems-1:0] buf_q;
  logic        m_fire;
  logic        advance;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_LAST_COLUMN) ? {26'd0, last_col_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LAST_COL_RESET;
    end else if (cfg_write && paddr[2] == REG_LAST_COLUMN) begin
      last_col_q <= pwdata[5:0];
    end
  end

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign advance       = in_valid_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && m_fire));
  assign s_axis_tready = !in_valid_q || advance;

  clt_step u_step (
    .char_byte_i   (in_byte_q),
    .last_column_i (last_col_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .result_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '{cursor: ADDR_HOME, phase: ESC_IDLE, row_one: 1'b0};
      cnt_q      <= 2'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
        cnt_q   <= step_res.count;
      end else if (m_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      buf_q <= step_res.items;
    end else if (m_fire) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = buf_q[0].lcd_byte;
  assign m_axis_tuser  = buf_q[0].is_data;
  assign m_axis_tlast  = buf_q[0].last;

  // The head of the buffer carries tlast exactly when it is the only entry left.
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> buf_q[0].last)
    else $error("final buffered bus item lacks tlast");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 || cnt_q == 2'd3) |-> !buf_q[0].last)
    else $error("tlast set before the final bus item");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("pending text item lost before decode");

  a_decode_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (cnt_q == 2'd0 || buf_q[cnt_q - 2'd1].last))
    else $error("buffer loaded without tlast on its final entry");

endmodule

/* sv/clt_step.sv */
// ----------------------------------------------------------------------------
// clt_step
// Decodes one text byte against the terminal state: gives up to three bus
// items and the state that follows them.
// ----------------------------------------------------------------------------
module clt_step (
  input  logic [7:0]          char_byte_i,
  input  logic [5:0]          last_column_i,
  input  clt_pkg::term_state_t state_i,
  output clt_pkg::term_state_t state_o,
  output clt_pkg::step_out_t   result_o
);
  import clt_pkg::*;

  logic [6:0] bs_first_addr;
  logic [7:0] bs_first_cmd;
  logic [7:0] bs_second_cmd;
  logic [7:0] esc_cmd;
  logic [7:0] esc_base;
  logic       wrap_home;
  logic       wrap_line2;
  logic [7:0] chr_byte;

  always_comb begin
    bs_first_cmd  = bs_cmd(state_i.cursor, last_column_i);
    // The space written after the first command advances from that target.
    bs_first_addr = adv_addr(bs_first_cmd[6:0]);
    bs_second_cmd = bs_cmd(bs_first_addr, last_column_i);

    esc_base = state_i.row_one ? CMD_LINE2 : CMD_SET_DDRAM;
    esc_cmd  = esc_base + char_byte_i - ESC_OFFSET;

    wrap_home  = {1'b0, state_i.cursor} > ({1'b0, ADDR_LINE2} + {2'b00, last_column_i});
    wrap_line2 = (state_i.cursor > {1'b0, last_column_i}) && (state_i.cursor < LINE_LENGTH);
    chr_byte   = {1'b0, char_byte_i[6:0]};
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (state_i.phase)
      ESC_EQ: begin
        state_o.phase = ESC_ROW;
      end
      ESC_ROW: begin
        state_o.row_one = (char_byte_i == ESC_ROW_ONE);
        state_o.phase   = ESC_COL;
      end
      ESC_COL: begin
        state_o.phase     = ESC_IDLE;
        result_o.count    = 2'd1;
        result_o.items[0] = '{lcd_byte: esc_cmd, is_data: 1'b0, last: 1'b1};
        if (esc_cmd[7]) begin
          state_o.cursor = esc_cmd[6:0];
        end else if (esc_cmd >= 8'h01 && esc_cmd <= 8'h03) begin
          // Clear and home commands reset the address.
          state_o.cursor = ADDR_HOME;
        end
      end
      ESC_IDLE: begin
        if (char_byte_i == CHR_NUL) begin
          state_o = state_i;
        end else if (char_byte_i == CHR_ESC) begin
          state_o.phase = ESC_EQ;
        end else if (char_byte_i == CHR_BS) begin
          result_o.count    = 2'd3;
          result_o.items[0] = '{lcd_byte: bs_first_cmd, is_data: 1'b0, last: 1'b0};
          result_o.items[1] = '{lcd_byte: CHR_SPACE, is_data: 1'b1, last: 1'b0};
          result_o.items[2] = '{lcd_byte: bs_second_cmd, is_data: 1'b0, last: 1'b1};
          state_o.cursor    = bs_second_cmd[6:0];
        end else if (wrap_home) begin
          result_o.count    = 2'd2;
          result_o.items[0] = '{lcd_byte: CMD_SET_DDRAM, is_data: 1'b0, last: 1'b0};
          result_o.items[1] = '{lcd_byte: chr_byte, is_data: 1'b1, last: 1'b1};
          state_o.cursor    = adv_addr(ADDR_HOME);
        end else if (wrap_line2) begin
          result_o.count    = 2'd2;
          result_o.items[0] = '{lcd_byte: CMD_LINE2, is_data: 1'b0, last: 1'b0};
          result_o.items[1] = '{lcd_byte: chr_byte, is_data: 1'b1, last: 1'b1};
          state_o.cursor    = adv_addr(ADDR_LINE2);
        end else begin
          result_o.count    = 2'd1;
          result_o.items[0] = '{lcd_byte: chr_byte, is_data: 1'b1, last: 1'b1};
          state_o.cursor    = adv_addr(state_i.cursor);
        end
      end
      default: begin
        state_o.phase = ESC_IDLE;
      end
    endcase
  end

endmodule

/* tb/sv/lcd_bus_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_bus_checker
// Watches the text and LCD bus streams and the register port of the
// character LCD terminal, predicts the bus items of every text item from its
// own copy of the cursor, escape and column state, and compares each bus item
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_bus_checker #(
  parameter logic [2:0] LastColAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        text_valid_i,
  input  logic        text_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        bus_valid_i,
  input  logic        bus_ready_i,
  input  logic [7:0]  bus_byte_i,
  input  logic        bus_is_data_i,
  input  logic        bus_last_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import clt_pkg::*;

  // Commands 0x01 to 0x03 clear the display or send it home.
  localparam logic [7:0] CMD_CLEAR_FIRST = 8'h01;
  localparam logic [7:0] CMD_CLEAR_LAST  = 8'h03;
  localparam logic [7:0] ESC_ROW_LINE2   = 8'h01;

  logic [6:0] cursor;
  esc_phase_e esc_phase;
  logic [7:0] esc_row;
  logic [5:0] last_col;
  bus_item_t  bus_items_due[$];
  bus_item_t  due;

  // Queues one predicted bus item and moves the cursor the way the display does.
  function automatic void emit_bus_item(input logic [7:0] b, input logic is_data);
    bus_items_due.push_back('{lcd_byte: b, is_data: is_data, last: 1'b0});
    if (is_data) begin
      if (cursor == ADDR_LINE1_END) begin
        cursor = ADDR_LINE2;
      end else if (cursor == ADDR_LINE2_END) begin
        cursor = ADDR_HOME;
      end else begin
        cursor = cursor + 7'd1;
      end
    end else if (b[7]) begin
      cursor = b[6:0];
    end else if (b >= CMD_CLEAR_FIRST && b <= CMD_CLEAR_LAST) begin
      cursor = ADDR_HOME;
    end
  endfunction

  function automatic logic [7:0] back_one_cmd();
    logic [6:0] spot;
    spot = cursor - 7'd1;
    if (cursor == ADDR_HOME) begin
      spot = ADDR_HOME;
    end else if (spot < ADDR_LINE2 && spot > {1'b0, last_col}) begin
      spot = {1'b0, last_col};
    end
    return CMD_SET_DDRAM | {1'b0, spot};
  endfunction

  function automatic void predict_bus_items(input logic [7:0] ch);
    int unsigned first;
    bus_item_t   tail;
    logic [7:0]  col;
    first = bus_items_due.size();
    case (esc_phase)
      ESC_EQ: begin
        esc_phase = ESC_ROW;
      end
      ESC_ROW: begin
        esc_row   = ch - ESC_OFFSET;
        esc_phase = ESC_COL;
      end
      ESC_COL: begin
        col       = ch - ESC_OFFSET;
        esc_phase = ESC_IDLE;
        emit_bus_item(((esc_row == ESC_ROW_LINE2) ? CMD_LINE2 : CMD_SET_DDRAM) + col, 1'b0);
      end
      default: begin
        if (ch == CHR_ESC) begin
          esc_phase = ESC_EQ;
        end else if (ch == CHR_BS) begin
          emit_bus_item(back_one_cmd(), 1'b0);
          emit_bus_item(CHR_SPACE, 1'b1);
          emit_bus_item(back_one_cmd(), 1'b0);
        end else if (ch != CHR_NUL) begin
          // Wrap before writing: off the end of line 2 goes home, off the end of
          // line 1 goes to the start of line 2.
          if (int'(cursor) > int'(ADDR_LINE2) + int'(last_col)) begin
            emit_bus_item(CMD_SET_DDRAM, 1'b0);
          end else if (int'(cursor) > int'(last_col) && cursor < LINE_LENGTH) begin
            emit_bus_item(CMD_LINE2, 1'b0);
          end
          emit_bus_item({1'b0, ch[6:0]}, 1'b1);
        end
      end
    endcase
    if (bus_items_due.size() > first) begin
      tail      = bus_items_due.pop_back();
      tail.last = 1'b1;
      bus_items_due.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor       = ADDR_HOME;
      esc_phase    = ESC_IDLE;
      esc_row      = 8'd0;
      last_col     = LAST_COL_RESET;
      fail_count_o = 0;
      bus_items_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == LastColAddr) begin
        last_col = pwdata_i[5:0];
      end
      if (text_valid_i && text_ready_i) begin
        predict_bus_items(text_byte_i);
      end
      if (bus_valid_i && bus_ready_i) begin
        if (bus_items_due.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) begin
            $display("unexpected LCD bus item at %0t: byte %02h data %0b last %0b",
                     $time, bus_byte_i, bus_is_data_i, bus_last_i);
          end
        end else begin
          due = bus_items_due.pop_front();
          if (due.lcd_byte !== bus_byte_i || due.is_data !== bus_is_data_i ||
              due.last !== bus_last_i) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("mismatch at %0t: expected %02h data %0b last %0b, got %02h %0b %0b",
                       $time, due.lcd_byte, due.is_data, due.last,
                       bus_byte_i, bus_is_data_i, bus_last_i);
            end
          end
        end
      end
    end
    pending_o <= bus_items_due.size();
  end

endmodule

/* tb/sv/char_lcd_text_terminal_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_terminal_tb
// Drives text bytes into the LCD terminal with random gaps on both streams,
// walks the last-column register through several values between phases and
// lets the checker compare every LCD bus item against its prediction.
// ----------------------------------------------------------------------------
module char_lcd_text_terminal_tb;
  import clt_pkg::*;

  localparam logic [2:0] REG_LAST_COLUMN = 3'd0;
  localparam logic [7:0] CHR_EQUALS      = 8'h3D;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned ItemsPerPhase  = 43;
  localparam int unsigned CycleLimit     = 400000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;
  bit          holding       = 1'b0;
  bit          sender_burst  = 1'b0;

  char_lcd_text_terminal u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lcd_bus_checker #(
    .LastColAddr (REG_LAST_COLUMN)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .text_valid_i  (s_axis_tvalid),
    .text_ready_i  (s_axis_tready),
    .text_byte_i   (s_axis_tdata),
    .bus_valid_i   (m_axis_tvalid),
    .bus_ready_i   (m_axis_tready),
    .bus_byte_i    (m_axis_tdata),
    .bus_is_data_i (m_axis_tuser),
    .bus_last_i    (m_axis_tlast),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  initial begin : bus_receiver
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        holding       = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        holding = 1'b0;
      end
      gap = idle_len();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(40, 120)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Valid stays high when the next item follows at once; whoever stops sending
  // must lower it in that same step.
  task automatic send_char(input logic [7:0] ch);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = sender_burst ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_escape(input logic [7:0] row, input logic [7:0] col);
    send_char(CHR_ESC);
    send_char(CHR_EQUALS);
    send_char(row);
    send_char(col);
  endtask

  task automatic send_random_text(inout int unsigned sent);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      send_char(8'($urandom_range(8'h20, 8'h7E)));
      sent++;
    end else if (pick < 56) begin
      send_char(8'($urandom_range(8'h80, 8'hFF)));
      sent++;
    end else if (pick < 70) begin
      send_char(CHR_BS);
      sent++;
    end else if (pick < 86) begin
      send_escape(ESC_OFFSET + 8'($urandom_range(0, 1)), ESC_OFFSET + 8'($urandom_range(0, 45)));
      sent += 4;
    end else if (pick < 90) begin
      // Any three bytes after an escape are taken as '=', row and column.
      send_char(CHR_ESC);
      repeat (3) send_char(8'($urandom_range(0, 255)));
      sent += 4;
    end else if (pick < 94) begin
      send_char(CHR_NUL);
    end else begin
      send_char(8'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_last_column(input logic [5:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_LAST_COLUMN;
    pwdata  <= {26'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned calls;
    logic [5:0]  setting;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed text with the reset column setting of 19.
    send_char(CHR_BS);                         // backspace at home
    send_char(CHR_NUL);
    send_char(8'hFF);                          // top bit is dropped
    send_char(8'h41);
    send_escape(ESC_ROW_ONE, ESC_OFFSET);      // start of line 2
    send_char(CHR_BS);                         // back to the end of line 1
    send_escape(ESC_OFFSET, ESC_OFFSET + 8'd30);
    send_char(CHR_BS);                         // clamped to the last column
    send_char(8'h78);
    send_char(8'h79);                          // wraps to line 2
    send_escape(ESC_ROW_ONE, ESC_OFFSET + 8'd20);
    send_char(8'h7A);                          // past the end of line 2, goes home
    // NUL, backspace and ESC are consumed inside an escape.
    send_char(CHR_ESC);
    send_char(CHR_NUL);
    send_char(CHR_BS);
    send_char(CHR_ESC);
    send_escape(ESC_OFFSET, 8'hA2);            // column wraps into a home command
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       setting = 6'd0;
        1:       setting = 6'd39;
        2:       setting = 6'd63;
        3:       setting = 6'd7;
        6:       setting = LAST_COL_RESET;
        default: setting = 6'($urandom_range(0, 63));
      endcase
      write_last_column(setting);
      if (p == 2) begin
        // Stall the bus long enough for the terminal to back up into its input.
        long_hold_req = 1'b1;
        while (!holding) @(posedge clk_i);
        sender_burst = 1'b1;
        repeat (20) send_random_text(sent);
        sender_burst = 1'b0;
        wait_drained();
      end
      sent  = 0;
      calls = 0;
      while (sent < ItemsPerPhase) begin
        if (calls % 16 == 0) begin
          sender_burst = ($urandom_range(0, 3) == 0);
        end
        send_random_text(sent);
        calls++;
      end
      sender_burst = 1'b0;
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
